>>> design/wbsp_pkg.sv
// Types and constants shared by the weight blob stream parser.
`timescale 1ns / 1ps
package wbsp_pkg;

    typedef enum logic [2:0] {
        PH_HEADER  = 3'd0,
        PH_NLEN    = 3'd1,
        PH_NAME    = 3'd2,
        PH_DTYPE   = 3'd3,
        PH_COUNT   = 3'd4,
        PH_PAYLOAD = 3'd5,
        PH_DONE    = 3'd6
    } t_phase;

    localparam logic [2:0] ROLE_HEADER  = 3'd0;
    localparam logic [2:0] ROLE_NLEN    = 3'd1;
    localparam logic [2:0] ROLE_NAME    = 3'd2;
    localparam logic [2:0] ROLE_DTYPE   = 3'd3;
    localparam logic [2:0] ROLE_COUNT   = 3'd4;
    localparam logic [2:0] ROLE_PAYLOAD = 3'd5;
    localparam logic [2:0] ROLE_DISCARD = 3'd6;

    localparam logic [2:0] ST_BUSY      = 3'd0;
    localparam logic [2:0] ST_OK        = 3'd1;
    localparam logic [2:0] ST_SHORT     = 3'd2;
    localparam logic [2:0] ST_MAGIC     = 3'd3;
    localparam logic [2:0] ST_VERSION   = 3'd4;
    localparam logic [2:0] ST_DTYPE     = 3'd5;
    localparam logic [2:0] ST_TRUNC     = 3'd6;
    localparam logic [2:0] ST_TRAILING  = 3'd7;

    // magic bytes, byte 0 in the low bits
    localparam logic [3:0][7:0] MAGIC_WORD   = 32'h0031_5752;
    localparam logic [3:0]      HDR_LAST_POS = 4'd11;
    localparam logic [31:0]     VERSION_OK   = 32'd1;
    localparam logic [7:0]      DTYPE_MAX    = 8'd3;

    typedef struct packed {
        logic [2:0]  byte_role;
        logic [31:0] entry_number;
        logic [1:0]  entry_type;
        logic [31:0] element_total;
        logic        entry_closed;
        logic [31:0] entries_declared;
        logic [2:0]  status;
    } t_result;

endpackage

>>> design/wbsp_core.sv
// Parse state and per-byte step logic of the weight blob stream parser.
`timescale 1ns / 1ps
module wbsp_core (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_accept,
    input  logic [7:0]        i_byte,
    input  logic              i_last,
    output wbsp_pkg::t_result o_result
);
    import wbsp_pkg::*;

    t_phase      r_phase, n_phase;
    logic [34:0] r_left, n_left;
    logic [3:0]  r_hpos, n_hpos;
    logic [1:0]  r_fshift, n_fshift;
    logic        r_magic_ok, n_magic_ok;
    logic [31:0] r_version, n_version;
    logic [31:0] r_declared, n_declared;
    logic [31:0] r_entry, n_entry;
    logic [1:0]  r_type, n_type;
    logic        r_failed, n_failed;
    logic [2:0]  r_fail_code, n_fail_code;
    logic        r_dtype_bad, n_dtype_bad;
    logic [31:0] r_elems, n_elems;

    logic [2:0]  role;
    logic [2:0]  code;
    logic        closed;
    logic [31:0] byte_w;
    logic [31:0] count_w;
    logic [34:0] payload_len;
    logic [31:0] entry_inc;
    logic [15:0] nlen_w;

    assign byte_w    = {24'd0, i_byte};
    assign count_w   = r_left[31:0] | (byte_w << {r_fshift, 3'b000});
    assign entry_inc = r_entry + 32'd1;
    assign nlen_w    = {i_byte, r_left[7:0]};

    always_comb begin
        case (r_type)
            2'd0:    payload_len = {3'd0, count_w};
            2'd1:    payload_len = {2'd0, count_w, 1'b0};
            2'd2:    payload_len = {1'd0, count_w, 2'b00};
            default: payload_len = {count_w, 3'b000};
        endcase
    end

    // outputs and data path
    always_comb begin
        role        = ROLE_DISCARD;
        code        = ST_BUSY;
        closed      = 1'b0;
        n_left      = r_left;
        n_hpos      = r_hpos;
        n_fshift    = r_fshift;
        n_magic_ok  = r_magic_ok;
        n_version   = r_version;
        n_declared  = r_declared;
        n_entry     = r_entry;
        n_type      = r_type;
        n_dtype_bad = r_dtype_bad;
        n_elems     = r_elems;
        if (!r_failed) begin
            case (r_phase)
                PH_HEADER: begin
                    role = ROLE_HEADER;
                    if (r_hpos < 4'd4) begin
                        if (i_byte != MAGIC_WORD[r_hpos[1:0]]) begin
                            n_magic_ok = 1'b0;
                        end
                    end else if (r_hpos < 4'd8) begin
                        n_version = r_version | (byte_w << {r_hpos[1:0], 3'b000});
                    end else if (r_hpos < 4'd12) begin
                        n_declared = r_declared | (byte_w << {r_hpos[1:0], 3'b000});
                    end
                    if (r_hpos >= HDR_LAST_POS) begin
                        n_fshift = 2'd0;
                        if (!r_magic_ok) begin
                            code = ST_MAGIC;
                        end else if (r_version != VERSION_OK) begin
                            code = ST_VERSION;
                        end
                    end else begin
                        n_hpos = r_hpos + 4'd1;
                        if (i_last) begin
                            code = ST_SHORT;
                        end
                    end
                end
                PH_NLEN: begin
                    role = ROLE_NLEN;
                    if (r_fshift == 2'd0) begin
                        n_left   = {27'd0, i_byte};
                        n_elems  = 32'd0;
                        n_fshift = 2'd1;
                    end else begin
                        n_left   = {19'd0, nlen_w};
                        n_fshift = 2'd0;
                    end
                end
                PH_NAME: begin
                    role = ROLE_NAME;
                    if (r_left <= 35'd1) begin
                        n_left = 35'd0;
                    end else begin
                        n_left = r_left - 35'd1;
                    end
                end
                PH_DTYPE: begin
                    role        = ROLE_DTYPE;
                    n_type      = i_byte[1:0];
                    n_dtype_bad = i_byte > DTYPE_MAX;
                    n_fshift    = 2'd0;
                    n_left      = 35'd0;
                end
                PH_COUNT: begin
                    role   = ROLE_COUNT;
                    n_left = {3'd0, count_w};
                    if (r_fshift == 2'd3) begin
                        n_elems = count_w;
                        if (r_dtype_bad) begin
                            code = ST_DTYPE;
                        end else begin
                            n_left = payload_len;
                            if (count_w == 32'd0) begin
                                closed   = 1'b1;
                                n_entry  = entry_inc;
                                n_fshift = 2'd0;
                            end
                        end
                    end else begin
                        n_fshift = r_fshift + 2'd1;
                    end
                end
                PH_PAYLOAD: begin
                    role = ROLE_PAYLOAD;
                    if (r_left <= 35'd1) begin
                        n_left   = 35'd0;
                        closed   = 1'b1;
                        n_entry  = entry_inc;
                        n_fshift = 2'd0;
                    end else begin
                        n_left = r_left - 35'd1;
                    end
                end
                default: begin
                    role = ROLE_DISCARD;
                    code = ST_TRAILING;
                end
            endcase
        end
        n_failed    = r_failed || (code != ST_BUSY);
        n_fail_code = (code != ST_BUSY) ? code : r_fail_code;
    end

    // next parse phase
    always_comb begin
        n_phase = r_phase;
        if (!r_failed) begin
            case (r_phase)
                PH_HEADER: begin
                    if (r_hpos >= HDR_LAST_POS && r_magic_ok && r_version == VERSION_OK) begin
                        n_phase = (n_declared != 32'd0) ? PH_NLEN : PH_DONE;
                    end
                end
                PH_NLEN: begin
                    if (r_fshift != 2'd0) begin
                        n_phase = (nlen_w != 16'd0) ? PH_NAME : PH_DTYPE;
                    end
                end
                PH_NAME: begin
                    if (r_left <= 35'd1) begin
                        n_phase = PH_DTYPE;
                    end
                end
                PH_DTYPE: begin
                    n_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    if (r_fshift == 2'd3 && !r_dtype_bad) begin
                        if (count_w == 32'd0) begin
                            n_phase = (entry_inc == r_declared) ? PH_DONE : PH_NLEN;
                        end else begin
                            n_phase = PH_PAYLOAD;
                        end
                    end
                end
                PH_PAYLOAD: begin
                    if (r_left <= 35'd1) begin
                        n_phase = (entry_inc == r_declared) ? PH_DONE : PH_NLEN;
                    end
                end
                default: begin
                    n_phase = r_phase;
                end
            endcase
        end
    end

    always_comb begin
        o_result.byte_role        = role;
        o_result.entry_number     = r_entry;
        o_result.entry_type       = n_type;
        o_result.element_total    = n_elems;
        o_result.entry_closed     = closed;
        o_result.entries_declared = n_declared;
        if (n_failed) begin
            o_result.status = n_fail_code;
        end else if (i_last) begin
            o_result.status = (n_phase == PH_DONE) ? ST_OK : ST_TRUNC;
        end else begin
            o_result.status = ST_BUSY;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (i_accept && i_last)) begin
            r_phase     <= PH_HEADER;
            r_left      <= 35'd0;
            r_hpos      <= 4'd0;
            r_fshift    <= 2'd0;
            r_magic_ok  <= 1'b1;
            r_version   <= 32'd0;
            r_declared  <= 32'd0;
            r_entry     <= 32'd0;
            r_type      <= 2'd0;
            r_failed    <= 1'b0;
            r_fail_code <= ST_BUSY;
            r_dtype_bad <= 1'b0;
            r_elems     <= 32'd0;
        end else if (i_accept) begin
            r_phase     <= n_phase;
            r_left      <= n_left;
            r_hpos      <= n_hpos;
            r_fshift    <= n_fshift;
            r_magic_ok  <= n_magic_ok;
            r_version   <= n_version;
            r_declared  <= n_declared;
            r_entry     <= n_entry;
            r_type      <= n_type;
            r_failed    <= n_failed;
            r_fail_code <= n_fail_code;
            r_dtype_bad <= n_dtype_bad;
            r_elems     <= n_elems;
        end
    end

    // once failed, the parse phase freezes until the blob ends
    a_fail_freeze: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_failed && !(i_accept && i_last)) |=> $stable(r_phase))
        else $error("phase moved after failure");

    a_fail_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> (r_fail_code != ST_BUSY && r_fail_code != ST_OK))
        else $error("failure without error code");

    a_close_role: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        closed |-> (role == ROLE_COUNT || role == ROLE_PAYLOAD))
        else $error("entry closed on wrong byte role");

endmodule

>>> design/weight_blob_stream_parser.sv
// Top level of the weight blob stream parser: stream ports and result register.
//
//  channel  | direction | contents
//  s_axis   | in        | tdata: data_byte[7:0]; tlast: last_byte
//  m_axis   | out       | tuser: byte_role; tdata: result fields, see port list
//
// One byte per cycle if not stalled; each result is registered on acceptance.
// The result register frees up in the cycle it is taken, so a stalled output
// only holds the input back while the register is full and not being read.
// Synchronous active-low reset returns the parser to the header phase; the
// byte marked last does the same after its own result is computed.
`timescale 1ns / 1ps
module weight_blob_stream_parser (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_s_axis_tvalid,
    output logic         o_s_axis_tready,
    input  logic [7:0]   i_s_axis_tdata,   // data_byte[7:0]
    input  logic         i_s_axis_tlast,
    output logic         o_m_axis_tvalid,
    input  logic         i_m_axis_tready,
    // entry_number[31:0], entry_type[33:32], element_total[65:34],
    // entry_closed[66], entries_declared[98:67], status[101:99], zero[103:102]
    output logic [103:0] o_m_axis_tdata,
    output logic [2:0]   o_m_axis_tuser    // byte_role[2:0]
);
    import wbsp_pkg::*;

    logic    accept;
    t_result step_res;
    t_result r_res;
    logic    r_out_valid;

    assign o_s_axis_tready = !r_out_valid || i_m_axis_tready;
    assign accept          = i_s_axis_tvalid && o_s_axis_tready;

    wbsp_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_accept (accept),
        .i_byte   (i_s_axis_tdata),
        .i_last   (i_s_axis_tlast),
        .o_result (step_res)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (accept) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_res <= step_res;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tuser  = r_res.byte_role;
    assign o_m_axis_tdata  = {2'b00, r_res.status, r_res.entries_declared,
                              r_res.entry_closed, r_res.element_total,
                              r_res.entry_type, r_res.entry_number};

    a_accept_valid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_m_axis_tvalid)
        else $error("accepted byte produced no result");

    a_last_verdict: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_s_axis_tlast) |=> (r_res.status != ST_BUSY))
        else $error("last byte without verdict");

    a_discard_open: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && r_res.byte_role == ROLE_DISCARD) |-> !r_res.entry_closed)
        else $error("discarded byte closed an entry");

endmodule

>>> tb/tb_weight_blob_stream_parser.sv
// Self-checking testbench for the weight blob stream parser: byte labels vs. a local predictor.
`timescale 1ns / 1ps
module tb_weight_blob_stream_parser;
    import wbsp_pkg::*;

    localparam int N_DIR    = 21;
    localparam int N_RANDOM = 1850;
    localparam int HOLD_LEN = 60;

    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       has_fix;
        t_result    fix;
    } t_row;

    // a one-byte short blob; then a header with one entry: empty name, dtype 3, zero elements; then one byte too many
    localparam t_row DIR_TABLE [N_DIR] = '{
        '{8'hFF, 1'b1, 1'b1, '{ROLE_HEADER, 32'd0, 2'd0, 32'd0, 1'b0, 32'd0, ST_SHORT}},
        '{8'h52, 1'b0, 1'b0, '0}, '{8'h57, 1'b0, 1'b0, '0},
        '{8'h31, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h01, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h03, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h00, 1'b0, 1'b0, '0}, '{8'h00, 1'b0, 1'b0, '0},
        '{8'h7F, 1'b1, 1'b1, '{ROLE_DISCARD, 32'd1, 2'd3, 32'd0, 1'b0, 32'd1, ST_TRAILING}}
    };

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [7:0]   i_s_axis_tdata = 8'd0;    // data_byte[7:0]
    logic         i_s_axis_tlast = 1'b0;
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [103:0] o_m_axis_tdata;           // entry_number, entry_type, element_total,
                                            // entry_closed, entries_declared, status
    logic [2:0]   o_m_axis_tuser;           // byte_role[2:0]

    weight_blob_stream_parser uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .i_s_axis_tlast  (i_s_axis_tlast),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    t_row       stim[$];
    logic [7:0] blob_q[$];
    t_result    label_q[$];
    int         n_blobs;
    int         bytes_in;
    int         labels_out;
    int         err_count;
    int         verdicts[8];
    int         send_idx;
    int         send_gap;
    int         recv_gap;
    logic       hold_out = 1'b0;

    // predictor state
    t_phase      pp_phase;
    logic [34:0] pp_left;
    logic [3:0]  pp_hpos;
    logic [1:0]  pp_field;
    logic        pp_magic_ok;
    logic [31:0] pp_version;
    logic [31:0] pp_declared;
    logic [31:0] pp_entry;
    logic [1:0]  pp_dtype;
    logic        pp_failed;
    logic [2:0]  pp_fail_st;
    logic        pp_dtype_bad;
    logic [31:0] pp_elems;

    function automatic void restart_parse();
        pp_phase     = PH_HEADER;
        pp_left      = '0;
        pp_hpos      = '0;
        pp_field     = '0;
        pp_magic_ok  = 1'b1;
        pp_version   = '0;
        pp_declared  = '0;
        pp_entry     = '0;
        pp_dtype     = '0;
        pp_failed    = 1'b0;
        pp_fail_st   = ST_BUSY;
        pp_dtype_bad = 1'b0;
        pp_elems     = '0;
    endfunction

    function automatic void finish_entry();
        pp_entry = pp_entry + 1;
        pp_phase = (pp_entry == pp_declared) ? PH_DONE : PH_NLEN;
        pp_field = '0;
    endfunction

    function automatic t_result label_byte(input logic [7:0] b, input logic lst);
        t_result    r;
        logic [2:0] code;
        r = '0;
        r.byte_role = ROLE_DISCARD;
        r.entry_number = pp_entry;
        code = ST_BUSY;
        if (!pp_failed) begin
            case (pp_phase)
                PH_HEADER: begin
                    r.byte_role = ROLE_HEADER;
                    if (pp_hpos < 4) begin
                        if (b != MAGIC_WORD[pp_hpos[1:0]]) pp_magic_ok = 1'b0;
                    end else if (pp_hpos < 8) begin
                        pp_version = pp_version | (32'(b) << (8 * (pp_hpos - 4)));
                    end else begin
                        pp_declared = pp_declared | (32'(b) << (8 * (pp_hpos - 8)));
                    end
                    if (pp_hpos >= HDR_LAST_POS) begin
                        if (!pp_magic_ok) code = ST_MAGIC;
                        else if (pp_version != VERSION_OK) code = ST_VERSION;
                        else pp_phase = (pp_declared != 0) ? PH_NLEN : PH_DONE;
                        pp_field = '0;
                    end else begin
                        pp_hpos = pp_hpos + 1;
                        if (lst) code = ST_SHORT;
                    end
                end
                PH_NLEN: begin
                    r.byte_role = ROLE_NLEN;
                    if (pp_field == 0) begin
                        pp_left = 35'(b);
                        pp_elems = '0;
                        pp_field = 2'd1;
                    end else begin
                        pp_left = {19'd0, b, pp_left[7:0]};
                        pp_field = '0;
                        pp_phase = (pp_left != 0) ? PH_NAME : PH_DTYPE;
                    end
                end
                PH_NAME: begin
                    r.byte_role = ROLE_NAME;
                    if (pp_left <= 1) begin
                        pp_left = '0;
                        pp_phase = PH_DTYPE;
                    end else begin
                        pp_left = pp_left - 1;
                    end
                end
                PH_DTYPE: begin
                    r.byte_role = ROLE_DTYPE;
                    pp_dtype = b[1:0];
                    pp_dtype_bad = (b > DTYPE_MAX);
                    pp_field = '0;
                    pp_left = '0;
                    pp_phase = PH_COUNT;
                end
                PH_COUNT: begin
                    r.byte_role = ROLE_COUNT;
                    pp_left = pp_left | (35'(b) << (8 * pp_field));
                    if (pp_field == 2'd3) begin
                        pp_elems = pp_left[31:0];
                        if (pp_dtype_bad) begin
                            code = ST_DTYPE;
                        end else begin
                            // element size is 1 << dtype
                            pp_left = 35'(pp_elems) << pp_dtype;
                            if (pp_left == 0) begin
                                r.entry_closed = 1'b1;
                                finish_entry();
                            end else begin
                                pp_phase = PH_PAYLOAD;
                            end
                        end
                    end else begin
                        pp_field = pp_field + 1;
                    end
                end
                PH_PAYLOAD: begin
                    r.byte_role = ROLE_PAYLOAD;
                    if (pp_left <= 1) begin
                        pp_left = '0;
                        r.entry_closed = 1'b1;
                        finish_entry();
                    end else begin
                        pp_left = pp_left - 1;
                    end
                end
                default: begin
                    r.byte_role = ROLE_DISCARD;
                    code = ST_TRAILING;
                end
            endcase
            if (code != ST_BUSY) begin
                pp_failed = 1'b1;
                pp_fail_st = code;
            end
        end
        if (pp_failed) r.status = pp_fail_st;
        else if (lst) r.status = (pp_phase == PH_DONE) ? ST_OK : ST_TRUNC;
        else r.status = ST_BUSY;
        r.entry_type = pp_dtype;
        r.element_total = pp_elems;
        r.entries_declared = pp_declared;
        if (lst) restart_parse();
        return r;
    endfunction

    task automatic add_byte(input logic [7:0] v);
        blob_q.insert(blob_q.size(), v);
    endtask

    task automatic emit_le(input logic [31:0] v, input int n);
        for (int k = 0; k < n; k++) add_byte(v[8*k +: 8]);
    endtask

    // kinds: noise, bad magic, bad version, bad dtype, truncated, trailing, clean
    task automatic build_blob();
        int          kind;
        int          n_ent;
        int          bad_at;
        int          nlen;
        int          plen;
        int          cut;
        logic        big;
        logic        trunc;
        logic [31:0] decl_w;
        logic [31:0] ver_w;
        logic [31:0] cnt;
        logic [7:0]  dt;
        blob_q.delete();
        kind = $urandom_range(0, 99);
        if (kind < 8) begin
            repeat ($urandom_range(1, 24)) add_byte(8'($urandom));
        end else begin
            trunc = (kind >= 22 && kind < 32);
            n_ent = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 3);
            big = trunc && $urandom_range(0, 1);
            decl_w = (trunc && $urandom_range(0, 1)) ? $urandom : n_ent;
            emit_le(MAGIC_WORD, 4);
            if (kind < 12) blob_q[$urandom_range(0, 3)] ^= 8'($urandom_range(1, 255));
            ver_w = VERSION_OK;
            if (kind >= 12 && kind < 16) begin
                ver_w = $urandom;
                if (ver_w == VERSION_OK) ver_w = '0;
            end
            emit_le(ver_w, 4);
            emit_le(decl_w, 4);
            bad_at = (kind >= 16 && kind < 22) ? $urandom_range(0, n_ent) : -1;
            for (int e = 0; e < n_ent; e++) begin
                if (big && e == n_ent - 1 && $urandom_range(0, 1)) begin
                    emit_le($urandom_range(256, 65535), 2);
                    repeat (3) add_byte(8'($urandom));
                    break;
                end
                nlen = $urandom_range(0, 4);
                emit_le(nlen, 2);
                repeat (nlen) add_byte(8'($urandom));
                dt = (e == bad_at) ? 8'($urandom_range(4, 255)) : 8'($urandom_range(0, 3));
                add_byte(dt);
                cnt = (big && e == n_ent - 1) ? ($urandom | 32'h100) : $urandom_range(0, 3);
                emit_le(cnt, 4);
                if (e == bad_at) plen = 0;
                else if (big && e == n_ent - 1) plen = 3;
                else plen = cnt << dt[1:0];
                repeat (plen) add_byte(8'($urandom));
            end
            if (kind >= 32 && kind < 40) begin
                repeat ($urandom_range(1, 3)) add_byte(8'($urandom));
            end
            if (trunc && blob_q.size() > 1) begin
                cut = $urandom_range(1, blob_q.size() - 1);
                while (blob_q.size() > cut) void'(blob_q.pop_back());
            end
        end
        foreach (blob_q[k]) begin
            stim.insert(stim.size(), '{blob_q[k], (k == blob_q.size() - 1), 1'b0, '0});
        end
    endtask

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (want !== got) begin
            err_count++;
            $error("%s: expected %0d, actual %0d", name, want, got);
        end
    endtask

    // sender
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) send_idx++;
            if (!i_s_axis_tvalid || o_s_axis_tready) begin
                if (send_gap > 0) begin
                    send_gap--;
                    i_s_axis_tvalid <= 1'b0;
                end else if (send_idx < stim.size()) begin
                    i_s_axis_tvalid <= 1'b1;
                    i_s_axis_tdata <= stim[send_idx].data;
                    i_s_axis_tlast <= stim[send_idx].last;
                    if (send_idx < stim.size() - 200 && send_idx % 400 < 320 &&
                        $urandom_range(0, 9) == 0) send_gap = $urandom_range(1, 11);
                end else begin
                    i_s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // receiver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (hold_out) begin
                i_m_axis_tready <= 1'b0;
            end else if (recv_gap > 0) begin
                recv_gap--;
                i_m_axis_tready <= 1'b0;
            end else begin
                i_m_axis_tready <= 1'b1;
                if (labels_out < stim.size() - 200 && labels_out % 400 >= 80 &&
                    $urandom_range(0, 9) == 0) recv_gap = $urandom_range(1, 11);
            end
        end
    end

    // long output hold-off so the result register fills and the input stalls
    initial begin
        wait (bytes_in >= 400);
        @(posedge i_clk);
        hold_out <= 1'b1;
        repeat (HOLD_LEN) @(posedge i_clk);
        hold_out <= 1'b0;
    end

    // monitor: predict on input transaction, check on output transaction
    always @(posedge i_clk) begin
        t_result want;
        t_result pred;
        if (i_rst_n) begin
            if (i_s_axis_tvalid && o_s_axis_tready) begin
                pred = label_byte(i_s_axis_tdata, i_s_axis_tlast);
                want = stim[bytes_in].has_fix ? stim[bytes_in].fix : pred;
                if (i_s_axis_tlast) verdicts[pred.status]++;
                label_q.insert(label_q.size(), want);
                bytes_in++;
            end
            if (o_m_axis_tvalid && i_m_axis_tready) begin
                if (label_q.size() == 0) begin
                    err_count++;
                    $error("output transaction with no byte pending");
                end else begin
                    want = label_q.pop_front();
                    check_field("byte_role", want.byte_role, o_m_axis_tuser);
                    check_field("entry_number", want.entry_number, o_m_axis_tdata[31:0]);
                    check_field("entry_type", want.entry_type, o_m_axis_tdata[33:32]);
                    check_field("element_total", want.element_total, o_m_axis_tdata[65:34]);
                    check_field("entry_closed", want.entry_closed, o_m_axis_tdata[66]);
                    check_field("entries_declared", want.entries_declared,
                                o_m_axis_tdata[98:67]);
                    check_field("status", want.status, o_m_axis_tdata[101:99]);
                end
                labels_out++;
            end
        end
    end

    initial begin
        restart_parse();
        for (int i = 0; i < N_DIR; i++) stim.insert(stim.size(), DIR_TABLE[i]);
        while (stim.size() < N_DIR + N_RANDOM) begin
            build_blob();
            n_blobs++;
        end
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        wait (bytes_in == stim.size());
        wait (label_q.size() == 0);
        repeat (10) @(posedge i_clk);
        $display("Checked %0d byte labels over %0d random blobs plus the directed rows.",
                 labels_out, n_blobs);
        $display("Verdicts: ok %0d, short %0d, magic %0d, version %0d,",
                 verdicts[ST_OK], verdicts[ST_SHORT], verdicts[ST_MAGIC],
                 verdicts[ST_VERSION]);
        $display("          dtype %0d, trunc %0d, trailing %0d",
                 verdicts[ST_DTYPE], verdicts[ST_TRUNC], verdicts[ST_TRAILING]);
        if (err_count == 0 && label_q.size() == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

    initial begin
        #4_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule
